// ----- rtl/ssnf_pkg.sv -----
// Shared types, segment codes and message patterns for the number formatter.
`timescale 1ns / 1ps

package ssnf_pkg;

    localparam int unsigned MAG_W = 14;  // magnitudes are held saturated to 9999

    localparam logic [MAG_W-1:0] MAX_SHOWN = MAG_W'(9999);

    localparam logic [7:0] SEG_BLANK = 8'h00;
    localparam logic [7:0] SEG_MINUS = 8'h40;
    localparam logic [7:0] SEG_DOT   = 8'h80;
    localparam logic [7:0] SEG_A     = 8'h77;
    localparam logic [7:0] SEG_B     = 8'h7c;
    localparam logic [7:0] SEG_C     = 8'h39;
    localparam logic [7:0] SEG_D     = 8'h5e;
    localparam logic [7:0] SEG_E     = 8'h79;
    localparam logic [7:0] SEG_F     = 8'h71;
    localparam logic [7:0] SEG_H     = 8'h76;
    localparam logic [7:0] SEG_L     = 8'h38;
    localparam logic [7:0] SEG_O     = 8'h3f;
    localparam logic [7:0] SEG_P     = 8'h73;
    localparam logic [7:0] SEG_R     = 8'h50;

    // bit i set: message i writes the LED byte
    localparam logic [15:0] MSG_LED_MASK = 16'hDE00;

    typedef enum logic [1:0] {
        CMD_PLAIN = 2'd0,
        CMD_TEMP  = 2'd1,
        CMD_MSG   = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    // control word carried alongside the digits down the pipe
    typedef struct packed {
        t_cmd       cmd;
        logic       neg;
        logic [3:0] code;
        logic [7:0] led;
    } t_ctl;

    typedef struct packed {
        logic [7:0] thousands;
        logic [7:0] hundreds;
        logic [7:0] tens;
        logic [7:0] units;
    } t_disp;

    function automatic logic [7:0] seg_digit(input logic [3:0] digit);
        logic [7:0] seg;
        case (digit)
            4'd0:    seg = 8'h3f;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5b;
            4'd3:    seg = 8'h4f;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6d;
            4'd6:    seg = 8'h7d;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7f;
            4'd9:    seg = 8'h6f;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

    function automatic t_disp msg_pattern(input logic [3:0] code);
        t_disp p;
        case (code)
            4'd0:    p = '{SEG_MINUS, SEG_C, SEG_D, SEG_MINUS};
            4'd1:    p = '{SEG_MINUS, SEG_O, SEG_B, SEG_MINUS};
            4'd2:    p = '{SEG_MINUS, SEG_D, SEG_F, SEG_MINUS};
            4'd3:    p = '{SEG_MINUS, SEG_A, SEG_H, SEG_MINUS};
            4'd4:    p = '{SEG_MINUS, SEG_A, SEG_L, SEG_MINUS};
            4'd5:    p = '{SEG_MINUS, SEG_P, SEG_C, SEG_MINUS};
            4'd6:    p = '{SEG_MINUS, SEG_B, SEG_L, SEG_MINUS};
            4'd7:    p = '{SEG_MINUS, SEG_D, SEG_D, SEG_MINUS};
            4'd8:    p = '{SEG_MINUS, SEG_A, SEG_D, SEG_MINUS};
            4'd9:    p = '{SEG_MINUS, SEG_O, SEG_P, SEG_MINUS};
            4'd10:   p = '{SEG_MINUS, SEG_O, SEG_H, SEG_MINUS};
            4'd11:   p = '{SEG_MINUS, SEG_O, SEG_L, SEG_MINUS};
            4'd12:   p = '{SEG_MINUS, SEG_E, SEG_R, SEG_MINUS};
            4'd13:   p = '{SEG_BLANK, SEG_BLANK, SEG_BLANK, SEG_BLANK};
            4'd14:   p = '{SEG_L, SEG_E, SEG_A, SEG_D};
            4'd15:   p = '{SEG_D, SEG_O, SEG_O, SEG_R};
            default: p = '{SEG_BLANK, SEG_BLANK, SEG_BLANK, SEG_BLANK};
        endcase
        return p;
    endfunction

endpackage

// ----- rtl/ssnf_digit_peel.sv -----
// One decimal digit peeled off a magnitude by a bank of constant compares.
`timescale 1ns / 1ps

module ssnf_digit_peel
    import ssnf_pkg::*;
#(
    parameter int unsigned P_WEIGHT = 1000
) (
    input  logic [MAG_W-1:0] i_rem,
    output logic [3:0]       o_digit,
    output logic [MAG_W-1:0] o_rem
);

    // highest multiple not above the input wins; input stays below ten weights
    always_comb begin
        o_digit = 4'd0;
        o_rem   = i_rem;
        for (int k = 1; k <= 9; k++) begin
            if (i_rem >= MAG_W'(k * P_WEIGHT)) begin
                o_digit = 4'(k);
                o_rem   = i_rem - MAG_W'(k * P_WEIGHT);
            end
        end
    end

endmodule

// ----- rtl/seven_segment_number_formatter.sv -----
// Top level of the four-digit seven-segment number formatter.
`timescale 1ns / 1ps
//
// Usage:
//   Command channel: drive i_command, i_value, i_message_code and i_led_byte
//   and raise i_start for one cycle per word. A word is taken at every edge
//   where i_start is high and o_busy is low; o_busy is tied low, so a new
//   word may be issued in every cycle.
//   Result channel: o_strobe is high for exactly one cycle per word, with the
//   LED write flag, LED byte and four segment bytes (leftmost first, bit 7
//   the decimal point) on the result ports in that cycle.
//   Pipeline: a word passes through five register stages (sign/saturate,
//   thousands, hundreds, tens, segment encode), each one compare bank and a
//   subtract or a table lookup. Throughput: one word per cycle.
//   Reset (i_rst_n low, synchronous) clears the stage valid bits, dropping
//   any words in flight; payload registers are not reset.
//   The receiver cannot stall: results are shown once and never held.
//
module seven_segment_number_formatter
    import ssnf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_command,
    input  logic signed [14:0] i_value,
    input  logic [3:0]  i_message_code,
    input  logic [7:0]  i_led_byte,
    output logic        o_strobe,
    output logic        o_led_write,
    output logic [7:0]  o_led_out,
    output logic [7:0]  o_digit_thousands,
    output logic [7:0]  o_digit_hundreds,
    output logic [7:0]  o_digit_tens,
    output logic [7:0]  o_digit_units
);

    // stage valid bits, one per register stage
    logic r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_out_vld;

    t_ctl r_s1_ctl, r_s2_ctl, r_s3_ctl, r_s4_ctl;
    logic [MAG_W-1:0] r_s1_mag, r_s2_rem, r_s3_rem;
    logic [3:0] r_s2_th, r_s3_th, r_s4_th;
    logic [3:0] r_s3_hu, r_s4_hu;
    logic [3:0] r_s4_te, r_s4_un;

    logic       r_led_write;
    logic [7:0] r_led_out;
    t_disp      r_disp;

    // stage 1: sign, magnitude and saturation
    logic             n_neg;
    logic [14:0]      n_abs;
    logic [MAG_W-1:0] n_mag;
    t_ctl             n_s1_ctl;

    always_comb begin
        n_neg = i_value[14];
        n_abs = n_neg ? (15'd0 - i_value) : i_value;
        if (n_abs > 15'(MAX_SHOWN)) begin
            n_mag = MAX_SHOWN;
        end else begin
            n_mag = n_abs[MAG_W-1:0];
        end
        // plain mode shows negatives as zero
        if (t_cmd'(i_command) == CMD_PLAIN && n_neg) begin
            n_mag = '0;
        end
        n_s1_ctl = '{cmd: t_cmd'(i_command), neg: n_neg, code: i_message_code,
                     led: i_led_byte};
    end

    // stages 2 to 4: peel thousands, hundreds and tens
    logic [3:0]       n_th, n_hu, n_te;
    logic [MAG_W-1:0] n_rem_th, n_rem_hu, n_rem_te;

    ssnf_digit_peel #(.P_WEIGHT(1000)) u_peel_th (
        .i_rem   (r_s1_mag),
        .o_digit (n_th),
        .o_rem   (n_rem_th)
    );

    ssnf_digit_peel #(.P_WEIGHT(100)) u_peel_hu (
        .i_rem   (r_s2_rem),
        .o_digit (n_hu),
        .o_rem   (n_rem_hu)
    );

    ssnf_digit_peel #(.P_WEIGHT(10)) u_peel_te (
        .i_rem   (r_s3_rem),
        .o_digit (n_te),
        .o_rem   (n_rem_te)
    );

    // stage 5: blanking and segment encode
    logic       n_led_write;
    logic [7:0] n_led_out;
    t_disp      n_disp;
    logic       n_show_hu, n_show_te;

    always_comb begin
        n_led_write = 1'b0;
        n_led_out   = 8'h00;
        n_disp      = '{SEG_BLANK, SEG_BLANK, SEG_BLANK, SEG_BLANK};
        n_show_hu   = (r_s4_th != 4'd0) || (r_s4_hu != 4'd0);
        n_show_te   = n_show_hu || (r_s4_te != 4'd0);
        case (r_s4_ctl.cmd)
            CMD_PLAIN: begin
                if (r_s4_th != 4'd0) n_disp.thousands = seg_digit(r_s4_th);
                if (n_show_hu)       n_disp.hundreds  = seg_digit(r_s4_hu);
                if (n_show_te)       n_disp.tens      = seg_digit(r_s4_te);
                n_disp.units = seg_digit(r_s4_un);
            end
            CMD_TEMP: begin
                n_led_write = 1'b1;
                n_led_out   = r_s4_ctl.led;
                if (r_s4_ctl.neg) begin
                    n_disp.thousands = SEG_MINUS;
                end else if (r_s4_th != 4'd0) begin
                    n_disp.thousands = seg_digit(r_s4_th);
                end
                if (n_show_hu) n_disp.hundreds = seg_digit(r_s4_hu);
                n_disp.tens  = seg_digit(r_s4_te) | SEG_DOT;
                n_disp.units = seg_digit(r_s4_un);
            end
            CMD_MSG: begin
                n_disp = msg_pattern(r_s4_ctl.code);
                if (MSG_LED_MASK[r_s4_ctl.code]) begin
                    n_led_write = 1'b1;
                    n_led_out   = r_s4_ctl.led;
                end
            end
            default: begin
                // unused command: all fields zero
                n_led_write = 1'b0;
            end
        endcase
    end

    // valid bits: clear on reset, advance every cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= i_start & ~o_busy;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_s4_vld  <= r_s3_vld;
            r_out_vld <= r_s4_vld;
        end
    end

    // payload: advance unconditionally, the strobe marks what is live
    always_ff @(posedge i_clk) begin
        r_s1_ctl <= n_s1_ctl;
        r_s1_mag <= n_mag;

        r_s2_ctl <= r_s1_ctl;
        r_s2_th  <= n_th;
        r_s2_rem <= n_rem_th;

        r_s3_ctl <= r_s2_ctl;
        r_s3_th  <= r_s2_th;
        r_s3_hu  <= n_hu;
        r_s3_rem <= n_rem_hu;

        r_s4_ctl <= r_s3_ctl;
        r_s4_th  <= r_s3_th;
        r_s4_hu  <= r_s3_hu;
        r_s4_te  <= n_te;
        r_s4_un  <= n_rem_te[3:0];

        r_led_write <= n_led_write;
        r_led_out   <= n_led_out;
        r_disp      <= n_disp;
    end

    assign o_busy            = 1'b0;
    assign o_strobe          = r_out_vld;
    assign o_led_write       = r_led_write;
    assign o_led_out         = r_led_out;
    assign o_digit_thousands = r_disp.thousands;
    assign o_digit_hundreds  = r_disp.hundreds;
    assign o_digit_tens      = r_disp.tens;
    assign o_digit_units     = r_disp.units;

endmodule

// ----- verif/seven_segment_number_formatter_tb.sv -----
// Self-checking testbench for the four-digit seven-segment number formatter.
`timescale 1ns / 1ps

module seven_segment_number_formatter_tb
    import ssnf_pkg::*;
();

    // One display word as it leaves the block: LED write flag, LED byte and the
    // four segment bytes, leftmost digit first.
    typedef struct packed {
        logic       led_write;
        logic [7:0] led_out;
        logic [7:0] thousands;
        logic [7:0] hundreds;
        logic [7:0] tens;
        logic [7:0] units;
    } t_display;

    // Predicts the segment pattern of every accepted command word, holds the
    // patterns in arrival order and checks each strobed result against the
    // oldest one.
    class segment_scoreboard;
        t_display    awaited_displays[$];
        int unsigned faults;
        int unsigned reported;

        function new();
            faults   = 0;
            reported = 0;
        endfunction

        function logic [7:0] digit_glyph(int unsigned n);
            logic [7:0] g;
            case (n)
                0:       g = 8'h3f;
                1:       g = 8'h06;
                2:       g = 8'h5b;
                3:       g = 8'h4f;
                4:       g = 8'h66;
                5:       g = 8'h6d;
                6:       g = 8'h7d;
                7:       g = 8'h07;
                8:       g = 8'h7f;
                default: g = 8'h6f;
            endcase
            return g;
        endfunction

        // Letter patterns, thousands in the top byte.
        function logic [31:0] message_glyphs(logic [3:0] code);
            logic [31:0] p;
            case (code)
                4'd0:    p = 32'h40_39_5e_40;
                4'd1:    p = 32'h40_3f_7c_40;
                4'd2:    p = 32'h40_5e_71_40;
                4'd3:    p = 32'h40_77_76_40;
                4'd4:    p = 32'h40_77_38_40;
                4'd5:    p = 32'h40_73_39_40;
                4'd6:    p = 32'h40_7c_38_40;
                4'd7:    p = 32'h40_5e_5e_40;
                4'd8:    p = 32'h40_77_5e_40;
                4'd9:    p = 32'h40_3f_73_40;
                4'd10:   p = 32'h40_3f_76_40;
                4'd11:   p = 32'h40_3f_38_40;
                4'd12:   p = 32'h40_79_50_40;
                4'd13:   p = 32'h00_00_00_00;
                4'd14:   p = 32'h38_79_77_5e;
                default: p = 32'h5e_3f_3f_50;
            endcase
            return p;
        endfunction

        function t_display predict_display(t_cmd cmd, logic [14:0] raw, logic [3:0] code,
                                           logic [7:0] led);
            t_display    d;
            logic        neg;
            int unsigned mag;
            logic [31:0] glyphs;
            d      = '0;
            neg    = raw[14];
            mag    = neg ? (32'h8000 - {17'd0, raw}) : {17'd0, raw};
            // clamp anything beyond four digits
            if (mag > 9999) mag = 9999;
            case (cmd)
                CMD_PLAIN: begin
                    // negatives show as a lone zero
                    if (neg) mag = 0;
                    if (mag >= 1000) d.thousands = digit_glyph((mag / 1000) % 10);
                    if (mag >= 100)  d.hundreds  = digit_glyph((mag / 100) % 10);
                    if (mag >= 10)   d.tens      = digit_glyph((mag / 10) % 10);
                    d.units = digit_glyph(mag % 10);
                end
                CMD_TEMP: begin
                    d.led_write = 1'b1;
                    d.led_out   = led;
                    if (neg)
                        d.thousands = SEG_MINUS;
                    else if (mag >= 1000)
                        d.thousands = digit_glyph((mag / 1000) % 10);
                    if (mag >= 100) d.hundreds = digit_glyph((mag / 100) % 10);
                    d.tens  = digit_glyph((mag / 10) % 10) | SEG_DOT;
                    d.units = digit_glyph(mag % 10);
                end
                CMD_MSG: begin
                    glyphs = message_glyphs(code);
                    {d.thousands, d.hundreds, d.tens, d.units} = glyphs;
                    if (MSG_LED_MASK[code]) begin
                        d.led_write = 1'b1;
                        d.led_out   = led;
                    end
                end
                default: d = '0;
            endcase
            return d;
        endfunction

        function void note_word(t_cmd cmd, logic [14:0] raw, logic [3:0] code, logic [7:0] led);
            awaited_displays.push_back(predict_display(cmd, raw, code, led));
        endfunction

        function void check_result(t_display got);
            t_display want;
            if (awaited_displays.size() == 0) begin
                faults++;
                if (reported < 10) begin
                    reported++;
                    $display("%0t: unexpected result lw=%0b led=%02h digits=%02h %02h %02h %02h",
                             $realtime, got.led_write, got.led_out, got.thousands,
                             got.hundreds, got.tens, got.units);
                end
                return;
            end
            want = awaited_displays.pop_front();
            if (got !== want) begin
                faults++;
                if (reported < 10) begin
                    reported++;
                    $display("%0t: mismatch exp lw=%0b led=%02h digits=%02h %02h %02h %02h",
                             $realtime, want.led_write, want.led_out, want.thousands,
                             want.hundreds, want.tens, want.units);
                    $display("%0t:          got lw=%0b led=%02h digits=%02h %02h %02h %02h",
                             $realtime, got.led_write, got.led_out, got.thousands,
                             got.hundreds, got.tens, got.units);
                end
            end
        endfunction
    endclass

    localparam int unsigned RANDOM_WORDS = 1800;
    localparam int unsigned GAP_PERCENT  = 31;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_start        = 1'b0;
    logic [1:0]  i_command      = CMD_PLAIN;
    logic signed [14:0] i_value = '0;
    logic [3:0]  i_message_code = '0;
    logic [7:0]  i_led_byte     = '0;
    logic        o_busy;
    logic        o_strobe;
    logic        o_led_write;
    logic [7:0]  o_led_out;
    logic [7:0]  o_digit_thousands;
    logic [7:0]  o_digit_hundreds;
    logic [7:0]  o_digit_tens;
    logic [7:0]  o_digit_units;

    segment_scoreboard scoreboard = new();
    bit                gaps_on    = 1'b1;

    seven_segment_number_formatter uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_command         (i_command),
        .i_value           (i_value),
        .i_message_code    (i_message_code),
        .i_led_byte        (i_led_byte),
        .o_strobe          (o_strobe),
        .o_led_write       (o_led_write),
        .o_led_out         (o_led_out),
        .o_digit_thousands (o_digit_thousands),
        .o_digit_hundreds  (o_digit_hundreds),
        .o_digit_tens      (o_digit_tens),
        .o_digit_units     (o_digit_units)
    );

    always #4 i_clk = ~i_clk;

    // Monitor: everything here reads the values that held just before the
    // edge, so the driver's nonblocking updates at the same edge never leak in.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // any strobe that is not a clean zero counts as a result
            if (o_strobe !== 1'b0)
                scoreboard.check_result('{o_led_write, o_led_out, o_digit_thousands,
                                          o_digit_hundreds, o_digit_tens, o_digit_units});
            if (i_start && o_busy === 1'b0)
                scoreboard.note_word(t_cmd'(i_command), i_value, i_message_code, i_led_byte);
        end
    end

    // Offer one command word; hold it until the block takes it. Random gaps go in
    // front, with junk on the payload so that nothing depends on it while idle.
    task automatic send_word(input t_cmd cmd, input logic [14:0] value,
                             input logic [3:0] code, input logic [7:0] led);
        while (gaps_on && $urandom_range(99) < GAP_PERCENT) begin
            i_start        <= 1'b0;
            i_command      <= 2'($urandom);
            i_value        <= 15'($urandom);
            i_message_code <= 4'($urandom);
            i_led_byte     <= 8'($urandom);
            @(posedge i_clk);
        end
        i_start        <= 1'b1;
        i_command      <= cmd;
        i_value        <= value;
        i_message_code <= code;
        i_led_byte     <= led;
        @(posedge i_clk);
        while (o_busy !== 1'b0) @(posedge i_clk);
    endtask

    // Drop start and wait for every awaited display to come back.
    task automatic drain_displays(input int unsigned limit);
        int unsigned waited;
        waited  = 0;
        i_start <= 1'b0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (scoreboard.awaited_displays.size() != 0 && waited < limit);
    endtask

    // Mostly in-range numbers, weighted towards the digit boundaries, plus raw
    // 15-bit patterns so every bit and the saturating range get exercised.
    function automatic logic [14:0] pick_value();
        int v;
        case ($urandom_range(9))
            0, 1, 2: v = int'($urandom_range(2400)) - 1200;
            3, 4, 5: v = int'($urandom_range(19998)) - 9999;
            6:       v = int'($urandom_range(40)) - 20;
            default: return 15'($urandom);
        endcase
        return 15'(v);
    endfunction

    function automatic t_cmd pick_command();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 30) return CMD_PLAIN;
        if (r < 60) return CMD_TEMP;
        if (r < 92) return CMD_MSG;
        return CMD_NOP;
    endfunction

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words: digit boundaries, saturation, negatives, every message.
        send_word(CMD_PLAIN, 15'sd0, 4'd0, 8'hFF);
        send_word(CMD_PLAIN, 15'sd99, 4'd0, 8'h00);
        send_word(CMD_PLAIN, 15'sd1000, 4'd0, 8'hFF);
        send_word(CMD_PLAIN, 15'h3FFF, 4'd0, 8'h00);       // largest positive, clamps
        send_word(CMD_PLAIN, -15'sd1, 4'd0, 8'hFF);         // negative shows as zero
        send_word(CMD_TEMP, 15'sd7, 4'd0, 8'h00);
        send_word(CMD_TEMP, -15'sd100, 4'd15, 8'hFF);
        send_word(CMD_TEMP, 15'h4000, 4'd0, 8'hA5);         // most negative, clamps
        send_word(CMD_NOP, 15'h7FFF, 4'hF, 8'hFF);
        for (int c = 0; c < 16; c++)
            send_word(CMD_MSG, 15'($urandom), 4'(c), 8'($urandom));

        // Hold off until the pipe is empty once.
        drain_displays(1000);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            // a long back-to-back stretch in the middle of the run
            gaps_on = !(n >= 700 && n < 1100);
            if (n == 1300) drain_displays(1000);
            send_word(pick_command(), pick_value(), 4'($urandom), 8'($urandom));
        end

        drain_displays(1000);
        repeat (12) @(posedge i_clk);

        if (scoreboard.faults == 0 && scoreboard.awaited_displays.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ssnf_pkg.sv
rtl/ssnf_digit_peel.sv
rtl/seven_segment_number_formatter.sv
verif/seven_segment_number_formatter_tb.sv
